### hdl/svm_gd_pkg.sv
// ----------------------------------------------------------------------------
// svm_gd_pkg
// shared types and constants for the linear svm gradient-descent trainer
// ----------------------------------------------------------------------------
package svm_gd_pkg;

    localparam int DEF_MAX_POINTS = 1024;

    localparam int CFG_WIDTH  = 24;
    localparam int COORD_W    = 16;
    localparam int WEIGHT_W   = 48;
    localparam int EPOCH_W    = 24;

    localparam logic [CFG_WIDTH-1:0] LR_RESET  = 24'd8389;
    localparam logic [CFG_WIDTH-1:0] THR_RESET = 24'd16777;
    localparam logic [CFG_WIDTH-1:0] MAX_RESET = 24'd1048575;

    localparam logic [1:0] CFG_LEARNING_RATE  = 2'd0;
    localparam logic [1:0] CFG_STOP_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_MAX_EPOCHS     = 2'd2;

    // weights in q24.24
    localparam logic signed [WEIGHT_W-1:0] W_ONE  = 48'sh0000_0100_0000;
    localparam logic signed [WEIGHT_W-1:0] W_MAXV = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [WEIGHT_W-1:0] W_MINV = 48'sh8000_0000_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_one;
        logic signed [COORD_W-1:0] coord_two;
        logic                      label_negative;
        logic                      last_point;
    } point_t;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] weight_one;
        logic signed [WEIGHT_W-1:0] weight_two;
        logic signed [WEIGHT_W-1:0] bias;
        logic                       converged;
        logic [EPOCH_W-1:0]         epochs_used;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_CLEAR,
        S_SCAN,
        S_DRAIN,
        S_TEST,
        S_MUL,
        S_DIV,
        S_UPD,
        S_FINISH
    } state_t;

endpackage

### hdl/linear_svm_hinge_gd_trainer.sv
// ----------------------------------------------------------------------------
// linear_svm_hinge_gd_trainer
// Points are taken one per cycle while idle and written into an on-chip point
// memory of MAX_POINTS entries; points beyond that are dropped. The transaction
// marked last_point starts training of w1*x1 + w2*x2 + b from 1, 1, 0 by
// full-batch hinge-loss subgradient descent; no point is taken until the result
// has been handed to the result register. One epoch streams all n stored points
// through a four-stage margin pipeline, tests the three mean gradients and, if
// not converged and under the epoch limit, updates each weight with a multiply
// and a DW-bit bit-serial divide by n, DW = $clog2(MAX_POINTS+1) + 33. The
// number of epochs is set by convergence or by max_epochs. The user
// must write configuration registers only while the block idles (not enforced).
// ----------------------------------------------------------------------------
module linear_svm_hinge_gd_trainer #(
    parameter int MAX_POINTS = svm_gd_pkg::DEF_MAX_POINTS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                point_valid,
    output logic                                point_ready,
    input  svm_gd_pkg::point_t                  point,
    output logic                                result_valid,
    input  logic                                result_ready,
    output svm_gd_pkg::result_t                 result,
    input  logic                                cfg_write,
    input  logic [1:0]                          cfg_index,
    input  logic [svm_gd_pkg::CFG_WIDTH-1:0]    cfg_data
);
    import svm_gd_pkg::*;

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int SW   = CW + 17;
    localparam int PW   = SW + CFG_WIDTH;
    localparam int DW   = PW - 8;
    localparam int DCW  = $clog2(DW + 1);
    localparam int TW   = CFG_WIDTH + CW;
    localparam int CMPW = SW + 16;
    localparam int MW   = 2 * COORD_W + 1;
    localparam int XW   = 67;

    localparam logic signed [XW-1:0] MARGIN_POS = 67'sh1_0000_0000;
    localparam logic signed [XW-1:0] MARGIN_NEG = -67'sh1_0000_0000;

    state_t state_reg, state_next;

    logic [CFG_WIDTH-1:0] lr_reg, thr_reg, max_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        issue_reg;
    logic [TW-1:0]        thr_n_reg;
    logic [EPOCH_W-1:0]   epoch_reg;
    logic [1:0]           k_reg;
    logic                 conv_reg;

    logic signed [WEIGHT_W-1:0] w_reg [3];
    logic signed [SW-1:0]       sum_reg [3];

    // point memory
    logic [MW-1:0] mem [MAX_POINTS];
    logic [MW-1:0] rd_reg;
    logic          mem_we;
    logic          mem_re;

    // margin pipeline
    logic                        v1_reg, v2_reg, v3_reg;
    logic signed [63:0]          p1_reg, p2_reg;
    logic signed [COORD_W-1:0]   x1_2_reg, x2_2_reg, x1_3_reg, x2_3_reg;
    logic                        lab2_reg, lab3_reg, act3_reg;
    logic signed [XW-1:0]        margin;

    // update unit
    logic [DW-1:0]  dvd_reg;
    logic [CW-1:0]  rem_reg;
    logic [DCW-1:0] div_cnt_reg;
    logic           neg_reg;
    logic [CW:0]    trial;
    logic           trial_ge;

    logic                 point_fire;
    logic                 result_load;
    logic [SW-1:0]        sum_mag;
    logic                 below;
    logic                 conv_next;
    logic signed [SW-1:0] sum_k;
    logic signed [WEIGHT_W:0] w_ext, q_ext, w_new;
    logic [PW-1:0]        prod;

    result_t result_reg;
    logic    result_valid_reg;

    assign point_fire  = point_valid && point_ready;
    assign result_load = (state_reg == S_FINISH) && (!result_valid_reg || result_ready);

    // ---------------- datapath combinational ----------------
    always_comb
    begin
        sum_k     = sum_reg[k_reg];
        sum_mag   = sum_k[SW-1] ? SW'(-sum_k) : SW'(sum_k);
        below     = {sum_mag, 16'b0} < CMPW'(thr_n_reg);
        conv_next = conv_reg && below;
        prod      = PW'(lr_reg) * PW'(sum_mag);
        trial     = {rem_reg, dvd_reg[DW-1]};
        trial_ge  = trial >= {1'b0, count_reg};
        w_ext     = {w_reg[k_reg][WEIGHT_W-1], w_reg[k_reg]};
        q_ext     = (WEIGHT_W+1)'(dvd_reg);
        w_new     = neg_reg ? (w_ext + q_ext) : (w_ext - q_ext);
        margin    = XW'(p1_reg) + XW'(p2_reg) + (XW'(w_reg[2]) <<< 8);
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (point_fire && point.last_point)
                    state_next = S_INIT;
            S_INIT:
                state_next = S_CLEAR;
            S_CLEAR:
                state_next = S_SCAN;
            S_SCAN:
                if (issue_reg + CW'(1) == count_reg)
                    state_next = S_DRAIN;
            S_DRAIN:
                if (!v1_reg && !v2_reg && !v3_reg)
                    state_next = S_TEST;
            S_TEST:
                if (k_reg == 2'd2)
                begin
                    if (conv_next || epoch_reg >= max_reg)
                        state_next = S_FINISH;
                    else
                        state_next = S_MUL;
                end
            S_MUL:
                state_next = S_DIV;
            S_DIV:
                if (div_cnt_reg == DCW'(DW - 1))
                    state_next = S_UPD;
            S_UPD:
                state_next = (k_reg == 2'd2) ? S_CLEAR : S_MUL;
            S_FINISH:
                if (result_load)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // ---------------- outputs of the sequencer ----------------
    always_comb
    begin
        point_ready = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                point_ready = 1'b1;
                mem_we      = point_valid && (count_reg < CW'(MAX_POINTS));
            end
            S_SCAN:
                mem_re = 1'b1;
            default:
            begin
                point_ready = 1'b0;
            end
        endcase
    end

    // ---------------- memory ----------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[count_reg[AW-1:0]] <= {point.coord_one, point.coord_two, point.label_negative};
        if (mem_re)
            rd_reg <= mem[issue_reg[AW-1:0]];
    end

    // ---------------- margin pipeline payload ----------------
    always_ff @(posedge clk)
    begin
        x1_2_reg <= rd_reg[MW-1 -: COORD_W];
        x2_2_reg <= rd_reg[COORD_W:1];
        lab2_reg <= rd_reg[0];
        p1_reg   <= w_reg[0] * $signed(rd_reg[MW-1 -: COORD_W]);
        p2_reg   <= w_reg[1] * $signed(rd_reg[COORD_W:1]);
        x1_3_reg <= x1_2_reg;
        x2_3_reg <= x2_2_reg;
        lab3_reg <= lab2_reg;
        act3_reg <= lab2_reg ? (margin > MARGIN_NEG) : (margin < MARGIN_POS);
    end

    // ---------------- control and state registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            lr_reg           <= LR_RESET;
            thr_reg          <= THR_RESET;
            max_reg          <= MAX_RESET;
            count_reg        <= '0;
            issue_reg        <= '0;
            thr_n_reg        <= '0;
            epoch_reg        <= '0;
            k_reg            <= '0;
            conv_reg         <= 1'b0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            div_cnt_reg      <= '0;
            neg_reg          <= 1'b0;
            rem_reg          <= '0;
            dvd_reg          <= '0;
            result_valid_reg <= 1'b0;
            w_reg[0]         <= W_ONE;
            w_reg[1]         <= W_ONE;
            w_reg[2]         <= '0;
            sum_reg[0]       <= '0;
            sum_reg[1]       <= '0;
            sum_reg[2]       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_LEARNING_RATE:  lr_reg  <= cfg_data;
                    CFG_STOP_THRESHOLD: thr_reg <= cfg_data;
                    CFG_MAX_EPOCHS:     max_reg <= cfg_data;
                    default:            lr_reg  <= lr_reg;
                endcase
            end

            if (point_fire && count_reg < CW'(MAX_POINTS))
                count_reg <= count_reg + CW'(1);

            v1_reg <= mem_re;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;

            // accumulate -x*y and -y*256
            if (v3_reg && act3_reg)
            begin
                if (lab3_reg)
                begin
                    sum_reg[0] <= sum_reg[0] + SW'(x1_3_reg);
                    sum_reg[1] <= sum_reg[1] + SW'(x2_3_reg);
                    sum_reg[2] <= sum_reg[2] + SW'(256);
                end
                else
                begin
                    sum_reg[0] <= sum_reg[0] - SW'(x1_3_reg);
                    sum_reg[1] <= sum_reg[1] - SW'(x2_3_reg);
                    sum_reg[2] <= sum_reg[2] - SW'(256);
                end
            end

            case (state_reg)
                S_INIT:
                begin
                    w_reg[0]  <= W_ONE;
                    w_reg[1]  <= W_ONE;
                    w_reg[2]  <= '0;
                    thr_n_reg <= TW'(thr_reg) * TW'(count_reg);
                    epoch_reg <= '0;
                end
                S_CLEAR:
                begin
                    sum_reg[0] <= '0;
                    sum_reg[1] <= '0;
                    sum_reg[2] <= '0;
                    issue_reg  <= '0;
                end
                S_SCAN:
                    issue_reg <= issue_reg + CW'(1);
                S_DRAIN:
                begin
                    k_reg    <= '0;
                    conv_reg <= 1'b1;
                end
                S_TEST:
                begin
                    conv_reg <= conv_next;
                    k_reg    <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                end
                S_MUL:
                begin
                    dvd_reg     <= DW'(prod >> 8);
                    neg_reg     <= sum_k[SW-1];
                    rem_reg     <= '0;
                    div_cnt_reg <= '0;
                end
                S_DIV:
                begin
                    // restoring divide by the point count, one quotient bit a cycle
                    rem_reg     <= trial_ge ? CW'(trial - {1'b0, count_reg}) : CW'(trial);
                    dvd_reg     <= {dvd_reg[DW-2:0], trial_ge};
                    div_cnt_reg <= div_cnt_reg + DCW'(1);
                end
                S_UPD:
                begin
                    if (w_new[WEIGHT_W] != w_new[WEIGHT_W-1])
                        w_reg[k_reg] <= w_new[WEIGHT_W] ? W_MINV : W_MAXV;
                    else
                        w_reg[k_reg] <= w_new[WEIGHT_W-1:0];
                    if (k_reg == 2'd2)
                    begin
                        k_reg     <= '0;
                        epoch_reg <= epoch_reg + EPOCH_W'(1);
                    end
                    else
                        k_reg <= k_reg + 2'd1;
                end
                default:
                    k_reg <= k_reg;
            endcase

            if (result_load)
            begin
                result_valid_reg <= 1'b1;
                count_reg        <= '0;
            end
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            result_reg.weight_one  <= w_reg[0];
            result_reg.weight_two  <= w_reg[1];
            result_reg.bias        <= w_reg[2];
            result_reg.converged   <= conv_reg;
            result_reg.epochs_used <= epoch_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> issue_reg < count_reg)
        else $error("scan address beyond stored points");

    a_unconverged_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && !conv_reg) |-> epoch_reg >= max_reg)
        else $error("training ended unconverged below epoch limit");

    a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        result_load |=> count_reg == '0)
        else $error("point count not cleared after training");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TEST |-> (!v1_reg && !v2_reg && !v3_reg))
        else $error("gradient test while margin pipeline busy");

endmodule
